// ----- hw/rtl/tssc_pkg.sv -----
package tssc_pkg;

  // payload widths fixed by the channel definitions
  localparam int TOTAL_W     = 16;
  localparam int NOW_W       = 32;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_INDEX_W = 2;

  // default parameter values
  localparam int COUNT_BITS_DEF = 16;
  localparam int TIME_BITS_DEF  = 32;

  // register reset values
  localparam logic [CFG_DATA_W-1:0] MIN_STEP_GAP_RST     = 16'd10;
  localparam logic [CFG_DATA_W-1:0] SEQUENCE_TIMEOUT_RST = 16'd500;
  localparam logic [CFG_DATA_W-1:0] SESSION_TIMEOUT_RST  = 16'd1000;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_MIN_STEP_GAP     = 2'd0,
    REG_SEQUENCE_TIMEOUT = 2'd1,
    REG_SESSION_TIMEOUT  = 2'd2
  } reg_index_t;

  // sequence phase
  typedef enum logic [2:0] {
    PH_IDLE = 3'd0,
    PH_A    = 3'd1,
    PH_B    = 3'd2,
    PH_C    = 3'd3,
    PH_DONE = 3'd4
  } phase_t;

  // sweep direction
  typedef enum logic [1:0] {
    DIR_NONE = 2'd0,
    DIR_FWD  = 2'd1,
    DIR_BACK = 2'd2
  } dir_t;

endpackage

// ----- hw/rtl/tssc_in_if.sv -----
interface tssc_in_if;
  import tssc_pkg::*;

  logic             valid;
  logic             ready;
  logic             sensor_a;
  logic             sensor_b;
  logic             sensor_c;
  logic [NOW_W-1:0] now_ticks;

  modport source (output valid, sensor_a, sensor_b, sensor_c, now_ticks, input ready);
  modport sink   (input valid, sensor_a, sensor_b, sensor_c, now_ticks, output ready);
endinterface

// ----- hw/rtl/tssc_out_if.sv -----
interface tssc_out_if;
  import tssc_pkg::*;

  logic               valid;
  logic               ready;
  logic [TOTAL_W-1:0] total_count;
  logic               counted;
  logic               sweep_backward;
  logic               session_active;
  logic               session_ended;

  modport source (output valid, total_count, counted, sweep_backward, session_active,
                  session_ended, input ready);
  modport sink   (input valid, total_count, counted, sweep_backward, session_active,
                  session_ended, output ready);
endinterface

// ----- hw/rtl/tssc_cfg_if.sv -----
interface tssc_cfg_if;
  import tssc_pkg::*;

  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] reg_index;
  logic [CFG_DATA_W-1:0]  wr_data;

  modport source (output valid, reg_index, wr_data, input ready);
  modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ----- hw/rtl/three_sensor_sweep_counter.sv -----
// channel   dir   handshake      payload
// in_ch     in    valid/ready    sensor_a, sensor_b, sensor_c, now_ticks
// out_ch    out   valid/ready    total_count, counted, sweep_backward,
//                                session_active, session_ended
// cfg_ch    in    valid/ready    reg_index, wr_data (always ready)
//
// one item per cycle while out_ch is not stalling; each result appears in the
// output register in the cycle after its item is accepted, set by a single
// pass of edge, gap and timeout compares on the state registers.
// in_ch.ready is high while the output register is empty or being taken.
// rst (synchronous) clears state to idle, levels to all ones, times to zero
// and loads the register defaults.
module three_sensor_sweep_counter #(
  parameter int COUNT_BITS = tssc_pkg::COUNT_BITS_DEF,
  parameter int TIME_BITS  = tssc_pkg::TIME_BITS_DEF
) (
  input logic      clk,
  input logic      rst,
  tssc_in_if.sink  in_ch,
  tssc_out_if.source out_ch,
  tssc_cfg_if.sink cfg_ch
);
  import tssc_pkg::*;

  localparam int WIDE_W = (COUNT_BITS > TOTAL_W) ? COUNT_BITS : TOTAL_W;

  // configuration registers
  logic [CFG_DATA_W-1:0] min_step_gap;
  logic [CFG_DATA_W-1:0] sequence_timeout;
  logic [CFG_DATA_W-1:0] session_timeout;

  // sequence state
  phase_t                seq_phase, seq_phase_next;
  dir_t                  sweep_dir, sweep_dir_next;
  logic [2:0]            prev_levels;
  logic [TIME_BITS-1:0]  seq_start_time, seq_start_time_next;
  logic [TIME_BITS-1:0]  last_step_time, last_step_time_next;
  logic [TIME_BITS-1:0]  last_count_time, last_count_time_next;
  logic                  counting_flag, counting_flag_next;
  logic [COUNT_BITS-1:0] sweep_total, sweep_total_next;

  // per-item decode
  logic                 accept;
  logic [2:0]           levels;
  logic [2:0]           fall;
  logic                 ea, eb, ec;
  logic [TIME_BITS-1:0] now;
  logic                 gap_ok;
  logic                 seq_late;
  logic                 counted_next;
  logic                 backward_next;
  logic                 ended_next;
  logic [WIDE_W-1:0]    total_wide;

  // output register
  logic                 out_valid;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = !out_valid || out_ch.ready;
  assign accept       = in_ch.valid && in_ch.ready;

  assign levels   = {in_ch.sensor_c, in_ch.sensor_b, in_ch.sensor_a};
  assign now      = in_ch.now_ticks[TIME_BITS-1:0];
  assign fall     = prev_levels & ~levels;
  assign ea       = fall[0];
  assign eb       = fall[1];
  assign ec       = fall[2];
  assign gap_ok   = (now - last_step_time) > TIME_BITS'(min_step_gap);
  assign seq_late = (now - seq_start_time) > TIME_BITS'(sequence_timeout);

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      min_step_gap     <= MIN_STEP_GAP_RST;
      sequence_timeout <= SEQUENCE_TIMEOUT_RST;
      session_timeout  <= SESSION_TIMEOUT_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.reg_index)
        REG_MIN_STEP_GAP:     min_step_gap     <= cfg_ch.wr_data;
        REG_SEQUENCE_TIMEOUT: sequence_timeout <= cfg_ch.wr_data;
        REG_SESSION_TIMEOUT:  session_timeout  <= cfg_ch.wr_data;
        default: ;
      endcase
    end
  end

  // sequence tracking, counting and session timeout
  always_comb begin
    seq_phase_next       = seq_phase;
    sweep_dir_next       = sweep_dir;
    seq_start_time_next  = seq_start_time;
    last_step_time_next  = last_step_time;
    last_count_time_next = last_count_time;
    counting_flag_next   = counting_flag;
    sweep_total_next     = sweep_total;
    counted_next         = 1'b0;
    backward_next        = 1'b0;
    ended_next           = 1'b0;

    unique case (seq_phase)
      PH_IDLE: begin
        if (ea || ec) begin
          seq_phase_next      = ea ? PH_A : PH_C;
          sweep_dir_next      = ea ? DIR_FWD : DIR_BACK;
          seq_start_time_next = now;
          last_step_time_next = now;
        end
      end
      PH_A, PH_C: begin
        if (eb && gap_ok) begin
          seq_phase_next      = PH_B;
          last_step_time_next = now;
        end else if (ea || ec || seq_late) begin
          seq_phase_next = PH_IDLE;
          sweep_dir_next = DIR_NONE;
        end
      end
      PH_B: begin
        if (sweep_dir == DIR_FWD) begin
          if (ec && gap_ok) begin
            seq_phase_next = PH_DONE;
          end else if (ea || eb || seq_late) begin
            seq_phase_next = PH_IDLE;
            sweep_dir_next = DIR_NONE;
          end
        end else if (sweep_dir == DIR_BACK) begin
          if (ea && gap_ok) begin
            seq_phase_next = PH_DONE;
          end else if (eb || ec || seq_late) begin
            seq_phase_next = PH_IDLE;
            sweep_dir_next = DIR_NONE;
          end
        end
      end
      PH_DONE: begin
        sweep_total_next     = sweep_total + COUNT_BITS'(1);
        last_count_time_next = now;
        counting_flag_next   = 1'b1;
        counted_next         = 1'b1;
        backward_next        = (sweep_dir == DIR_BACK);
        seq_phase_next       = PH_IDLE;
        sweep_dir_next       = DIR_NONE;
      end
      default: begin
        seq_phase_next = PH_IDLE;
        sweep_dir_next = DIR_NONE;
      end
    endcase

    // a counting item is excluded from the timeout check, so it never ends the session
    if (counting_flag && !counted_next &&
        (now - last_count_time) > TIME_BITS'(session_timeout)) begin
      counting_flag_next = 1'b0;
      ended_next         = 1'b1;
    end
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      seq_phase       <= PH_IDLE;
      sweep_dir       <= DIR_NONE;
      prev_levels     <= 3'b111;
      seq_start_time  <= '0;
      last_step_time  <= '0;
      last_count_time <= '0;
      counting_flag   <= 1'b0;
      sweep_total     <= '0;
    end else if (accept) begin
      seq_phase       <= seq_phase_next;
      sweep_dir       <= sweep_dir_next;
      prev_levels     <= levels;
      seq_start_time  <= seq_start_time_next;
      last_step_time  <= last_step_time_next;
      last_count_time <= last_count_time_next;
      counting_flag   <= counting_flag_next;
      sweep_total     <= sweep_total_next;
    end
  end

  assign total_wide = WIDE_W'(sweep_total_next);

  // output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (accept) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output payload
  always_ff @(posedge clk) begin
    if (accept) begin
      out_ch.total_count    <= total_wide[TOTAL_W-1:0];
      out_ch.counted        <= counted_next;
      out_ch.sweep_backward <= backward_next;
      out_ch.session_active <= counting_flag_next;
      out_ch.session_ended  <= ended_next;
    end
  end

  assign out_ch.valid = out_valid;

endmodule
